>>> sv/salc_pkg.sv
// Package with shared types, widths and codes for the set-associative LRU cache model.
`default_nettype none
package salc_pkg;

    // Default geometry of the line storage.
    localparam int DEF_MAX_SETS = 64;
    localparam int DEF_MAX_WAYS = 8;

    // Entries in the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Field widths.
    localparam int OPCODE_W   = 2;
    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 64;
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 32;
    localparam int OUTCOME_W  = 2;
    localparam int SET_BITS_W = 3;
    localparam int BLK_BITS_W = 6;
    localparam int WAYS_W     = 4;
    localparam int SPLIT_W    = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 104;
    localparam int M_PAD_W   = M_TDATA_W - (OUTCOME_W + 1 + 3 * CNT_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2
    } cfg_index_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2
    } opcode_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_FETCH = 2'b01,
        ST_EXEC  = 2'b10
    } back_state_t;

    // One cache line as kept in the tag store.
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } line_t;

endpackage
`default_nettype wire

>>> sv/salc_front.sv
// Front part: configuration registers and the split of each address into set, tag and way mask.
`default_nettype none
module salc_front #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8,
    parameter int SET_W    = 6
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [salc_pkg::S_TDATA_W-1:0]   s_tdata,
    output salc_pkg::opcode_t                     opcode,
    output logic [SET_W-1:0]                      set_idx,
    output logic [salc_pkg::TAG_W-1:0]            tag,
    output logic [MAX_WAYS-1:0]                   way_mask
);
    import salc_pkg::*;

    // Largest set-bit count whose set count still fits the storage.
    localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;

    logic [SET_BITS_W-1:0] set_bits_reg;
    logic [BLK_BITS_W-1:0] block_bits_reg;
    logic [WAYS_W-1:0]     ways_reg;

    logic [SET_BITS_W-1:0] usable_sb;
    logic [SPLIT_W-1:0]    split;
    logic [ADDR_W-1:0]     address;
    logic [ADDR_W-1:0]     shifted;
    logic [SET_W-1:0]      set_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            block_bits_reg <= '0;
            ways_reg       <= WAYS_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data[BLK_BITS_W-1:0];
                CFG_WAYS:       ways_reg       <= cfg_data[WAYS_W-1:0];
                default:        ;
            endcase
        end
    end

    assign address = s_tdata[OPCODE_W +: ADDR_W];
    assign opcode  = opcode_t'(s_tdata[OPCODE_W-1:0]);

    assign usable_sb = (32'(set_bits_reg) > SB_MAX) ? SET_BITS_W'(SB_MAX) : set_bits_reg;
    assign split     = SPLIT_W'(block_bits_reg) + SPLIT_W'(usable_sb);
    assign shifted   = address >> block_bits_reg;
    assign tag       = (split >= SPLIT_W'(ADDR_W)) ? '0 : (address >> split[5:0]);

    always_comb
    begin
        for (int j = 0; j < SET_W; j++)
        begin
            set_mask[j] = (32'(usable_sb) > j);
        end
        // A way is in use when it lies below the configured count; way 0 always is.
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            way_mask[w] = (w == 0) || (32'(ways_reg) > w);
        end
    end

    assign set_idx = shifted[SET_W-1:0] & set_mask;

endmodule
`default_nettype wire

>>> sv/salc_queue.sv
// Small first-in first-out queue that decouples the front and back parts.
`default_nettype none
module salc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

>>> sv/salc_back.sv
// Back part: tag store, hit search, LRU replacement, counters and the output register.
`default_nettype none
module salc_back #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8,
    parameter int SET_W    = 6,
    parameter int WAY_W    = 3
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_valid,
    output logic                                 q_pop,
    input  wire salc_pkg::opcode_t               q_opcode,
    input  wire logic [SET_W-1:0]                q_set,
    input  wire logic [salc_pkg::TAG_W-1:0]      q_tag,
    input  wire logic [MAX_WAYS-1:0]             q_way_mask,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [salc_pkg::M_TDATA_W-1:0]       m_tdata
);
    import salc_pkg::*;

    // Tag store: one row per set, all ways of the set side by side.
    line_t [MAX_WAYS-1:0] mem [MAX_SETS];
    logic  [MAX_SETS-1:0] row_init_reg;

    back_state_t state_reg, state_next;

    line_t [MAX_WAYS-1:0] rd_row_q;
    logic                 row_init_q;
    opcode_t              opcode_q;
    logic [SET_W-1:0]     set_q;
    logic [TAG_W-1:0]     tag_q;
    logic [MAX_WAYS-1:0]  way_mask_q;

    logic [STAMP_W-1:0] access_clock_reg;
    logic [CNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]   miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0]   evict_cnt_reg, evict_cnt_next;
    logic               out_valid_reg;
    outcome_t           outcome_reg;
    logic               extra_reg;

    logic                 fire;
    logic [MAX_WAYS-1:0]  line_vld;
    logic [MAX_WAYS-1:0]  hit_vec;
    logic [MAX_WAYS-1:0]  empty_vec;
    logic                 hit;
    logic                 has_empty;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     empty_way;
    logic [WAY_W-1:0]     lru_way;
    logic [STAMP_W-1:0]   least;
    logic [WAY_W-1:0]     touch_way;
    outcome_t             outcome;
    logic                 extra;
    logic [1:0]           hit_inc;
    line_t [MAX_WAYS-1:0] row_next;

    assign q_pop = (state_reg == ST_FETCH) && q_valid;
    assign fire  = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FETCH: if (q_valid) state_next = ST_EXEC;
            ST_EXEC:  if (fire)    state_next = ST_FETCH;
            default:  state_next = ST_FETCH;
        endcase
    end

    // Search of the set row captured when the access was popped from the queue.
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            line_vld[w]  = row_init_q && rd_row_q[w].valid;
            hit_vec[w]   = line_vld[w] && way_mask_q[w] && (rd_row_q[w].tag == tag_q);
            empty_vec[w] = !line_vld[w] && way_mask_q[w];
        end
        hit       = |hit_vec;
        has_empty = |empty_vec;

        hit_way   = '0;
        empty_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (empty_vec[w])
            begin
                empty_way = WAY_W'(w);
            end
        end

        // Least stamp among the ways in use; a strict compare keeps the lower way on a tie.
        least   = rd_row_q[0].stamp;
        lru_way = '0;
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (way_mask_q[w] && (rd_row_q[w].stamp < least))
            begin
                least   = rd_row_q[w].stamp;
                lru_way = WAY_W'(w);
            end
        end

        if (hit)
        begin
            touch_way = hit_way;
            outcome   = OUT_HIT;
        end
        else if (has_empty)
        begin
            touch_way = empty_way;
            outcome   = OUT_FILL;
        end
        else
        begin
            touch_way = lru_way;
            outcome   = OUT_EVICT;
        end

        for (int w = 0; w < MAX_WAYS; w++)
        begin
            row_next[w]       = rd_row_q[w];
            row_next[w].valid = line_vld[w];
        end
        row_next[touch_way].valid = 1'b1;
        row_next[touch_way].tag   = tag_q;
        row_next[touch_way].stamp = access_clock_reg;

        extra          = (opcode_q == OP_MODIFY);
        hit_inc        = {1'b0, hit} + {1'b0, extra};
        hit_cnt_next   = hit_cnt_reg + CNT_W'(hit_inc);
        miss_cnt_next  = miss_cnt_reg + CNT_W'(!hit);
        evict_cnt_next = evict_cnt_reg + CNT_W'(outcome == OUT_EVICT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_FETCH;
            row_init_reg     <= '0;
            access_clock_reg <= '0;
            hit_cnt_reg      <= '0;
            miss_cnt_reg     <= '0;
            evict_cnt_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                row_init_reg[set_q] <= 1'b1;
                access_clock_reg    <= access_clock_reg + STAMP_W'(1);
                hit_cnt_reg         <= hit_cnt_next;
                miss_cnt_reg        <= miss_cnt_next;
                evict_cnt_reg       <= evict_cnt_next;
                out_valid_reg       <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_row_q   <= mem[q_set];
            row_init_q <= row_init_reg[q_set];
            opcode_q   <= q_opcode;
            set_q      <= q_set;
            tag_q      <= q_tag;
            way_mask_q <= q_way_mask;
        end
        if (fire)
        begin
            mem[set_q]  <= row_next;
            outcome_reg <= outcome;
            extra_reg   <= extra;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), evict_cnt_reg, miss_cnt_reg, hit_cnt_reg,
                       extra_reg, outcome_reg};

`ifndef NO_ASSERTIONS
    a_evict_full_set: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (outcome == OUT_EVICT)) |-> ((line_vld & way_mask_q) == way_mask_q))
        else $error("eviction while a usable way is empty");
    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !hit) |=> (miss_cnt_reg == $past(miss_cnt_reg) + CNT_W'(1)))
        else $error("miss counter did not advance on a miss");
    a_clock_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(access_clock_reg))
        else $error("access clock moved without an access");
    a_pop_only_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !q_pop)
        else $error("queue popped while an access is in flight");
`endif

endmodule
`default_nettype wire

>>> sv/set_assoc_lru_cache_model_unit.sv
// Top level of the set-associative LRU cache model: front, queue and back parts.
// The back part handles one access at a time: it reads the tag-store row in its fetch state
// and compares and writes back in its exec state on the single memory port; the exec state
// stalls while the output register holds a result that has not been taken.
// Reset clears the configuration (set_bits 0, block_bits 0, ways 1), the counters, the access
// clock and one initialized flag per set; there is no clearing pass over the tag store.
`default_nettype none
module set_assoc_lru_cache_model_unit #(
    parameter int MAX_SETS = salc_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS = salc_pkg::DEF_MAX_WAYS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration writes: index 0 set_bits, 1 block_bits, 2 ways.
    input  wire logic                             cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Access stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [salc_pkg::S_TDATA_W-1:0]   s_tdata,  // opcode[1:0], address[65:2]
    // Result stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [salc_pkg::M_TDATA_W-1:0]        m_tdata   // outcome[1:0], extra_hit[2],
                                                            // hit_total[34:3],
                                                            // miss_total[66:35],
                                                            // eviction_total[98:67]
);
    import salc_pkg::*;

    // Index widths derived from the storage geometry.
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    // A queue entry carries the opcode, tag, set index and mask of ways in use.
    localparam int ENT_W = OPCODE_W + TAG_W + SET_W + MAX_WAYS;

    opcode_t             f_opcode;
    logic [SET_W-1:0]    f_set;
    logic [TAG_W-1:0]    f_tag;
    logic [MAX_WAYS-1:0] f_way_mask;

    logic                q_full;
    logic                q_push;
    logic                q_pop;
    logic                q_valid;
    logic [ENT_W-1:0]    q_in;
    logic [ENT_W-1:0]    q_out;

    // The front part classifies each access as it arrives: the address is split
    // into set and tag under the current configuration, and the usable ways are
    // turned into a mask.
    salc_front #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS),
        .SET_W    (SET_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .opcode    (f_opcode),
        .set_idx   (f_set),
        .tag       (f_tag),
        .way_mask  (f_way_mask)
    );

    // An input transfer is taken whenever the queue has room, so the input side
    // keeps moving while the back part waits on the output.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;
    assign q_in     = {f_way_mask, f_set, f_tag, f_opcode};

    salc_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    // The back part reads the set's row in its fetch state, then in its exec state
    // compares all ways, writes the updated row back and loads the output register.
    salc_back #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS),
        .SET_W    (SET_W),
        .WAY_W    (WAY_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_opcode   (opcode_t'(q_out[OPCODE_W-1:0])),
        .q_set      (q_out[OPCODE_W + TAG_W +: SET_W]),
        .q_tag      (q_out[OPCODE_W +: TAG_W]),
        .q_way_mask (q_out[OPCODE_W + TAG_W + SET_W +: MAX_WAYS]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the set-associative LRU cache model: stream stimulus and a line tracker.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import salc_pkg::*;

    // Opcode 3 has no name in the package; the block treats it as a load.
    localparam logic [OPCODE_W-1:0] OP_UNKNOWN = 2'd3;

    // Storage geometry used by the tracker, matching the default parameters.
    localparam int TRK_SETS = DEF_MAX_SETS;
    localparam int TRK_WAYS = DEF_MAX_WAYS;
    localparam int TRK_SET_BITS_MAX = 6;

    // Fields of one result transfer, from the top of m_tdata down to bit 0.
    typedef struct packed {
        logic [M_PAD_W-1:0] pad;
        logic [CNT_W-1:0]   evictions;
        logic [CNT_W-1:0]   misses;
        logic [CNT_W-1:0]   hits;
        logic               extra_hit;
        outcome_t           outcome;
    } access_result_t;

    // The tracker mirrors the tag store, the access clock, the counters and the
    // three geometry registers. Every accepted access is looked up here and the
    // outcome it must produce is queued; every result transfer is checked
    // against the oldest queued outcome.
    class cache_tracker;
        bit                 line_valid[TRK_SETS * TRK_WAYS];
        logic [TAG_W-1:0]   line_tag[TRK_SETS * TRK_WAYS];
        logic [STAMP_W-1:0] line_stamp[TRK_SETS * TRK_WAYS];
        logic [STAMP_W-1:0] access_clock;
        logic [CNT_W-1:0]   hit_count;
        logic [CNT_W-1:0]   miss_count;
        logic [CNT_W-1:0]   evict_count;
        logic [SET_BITS_W-1:0] set_bits;
        logic [BLK_BITS_W-1:0] block_bits;
        logic [WAYS_W-1:0]     ways;
        access_result_t     expected_outcomes[$];
        int                 errors;

        function new();
            for (int i = 0; i < TRK_SETS * TRK_WAYS; i++)
                line_valid[i] = 1'b0;
            access_clock = '0;
            hit_count = '0;
            miss_count = '0;
            evict_count = '0;
            set_bits = '0;
            block_bits = '0;
            ways = 4'd1;
            errors = 0;
        endfunction

        // A set-bit count that would exceed the storage falls back to the largest that fits.
        function int usable_set_bits();
            return (set_bits > TRK_SET_BITS_MAX) ? TRK_SET_BITS_MAX : int'(set_bits);
        endfunction

        // Zero ways behaves as one way, and anything above the storage as all of it.
        function int usable_ways();
            if (ways == 0)
                return 1;
            return (ways > TRK_WAYS) ? TRK_WAYS : int'(ways);
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_SET_BITS:   set_bits = value[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: block_bits = value[BLK_BITS_W-1:0];
                CFG_WAYS:       ways = value[WAYS_W-1:0];
                default:        ;
            endcase
        endfunction

        function void note_access(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] addr);
            int sb;
            int nw;
            int split;
            int set_idx;
            int base;
            int hit_way;
            int victim;
            int w;
            logic [TAG_W-1:0]   tag;
            logic [STAMP_W-1:0] least;
            access_result_t     res;
            sb = usable_set_bits();
            nw = usable_ways();
            split = int'(block_bits) + sb;
            set_idx = int'((addr >> block_bits) & ((64'd1 << sb) - 64'd1));
            // A split of 64 bits or more leaves no tag bits at all.
            tag = (split >= 64) ? '0 : (addr >> split);
            base = set_idx * TRK_WAYS;
            res = '0;
            hit_way = -1;
            for (w = 0; w < nw; w++)
                if (hit_way < 0 && line_valid[base + w] && line_tag[base + w] == tag)
                    hit_way = w;
            if (hit_way >= 0)
            begin
                line_stamp[base + hit_way] = access_clock;
                hit_count++;
                res.outcome = OUT_HIT;
            end
            else
            begin
                miss_count++;
                victim = -1;
                for (w = 0; w < nw; w++)
                    if (victim < 0 && !line_valid[base + w])
                        victim = w;
                if (victim >= 0)
                    res.outcome = OUT_FILL;
                else
                begin
                    // Least recently used way; the strict compare keeps the lowest index on a tie.
                    victim = 0;
                    least = line_stamp[base];
                    for (w = 1; w < nw; w++)
                        if (line_stamp[base + w] < least)
                        begin
                            least = line_stamp[base + w];
                            victim = w;
                        end
                    evict_count++;
                    res.outcome = OUT_EVICT;
                end
                line_valid[base + victim] = 1'b1;
                line_tag[base + victim] = tag;
                line_stamp[base + victim] = access_clock;
            end
            if (op == OP_MODIFY)
            begin
                hit_count++;
                res.extra_hit = 1'b1;
            end
            access_clock++;
            res.hits = hit_count;
            res.misses = miss_count;
            res.evictions = evict_count;
            expected_outcomes.push_back(res);
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] exp_val,
                                    logic [CNT_W-1:0] act_val);
            if (exp_val !== act_val)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_outcome(logic [M_TDATA_W-1:0] data);
            access_result_t got;
            access_result_t exp;
            got = access_result_t'(data);
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result transfer, expected none actual %0h",
                         $time, data);
                errors++;
                return;
            end
            exp = expected_outcomes.pop_front();
            compare_field("outcome", 32'(exp.outcome), 32'(got.outcome));
            compare_field("extra_hit", 32'(exp.extra_hit), 32'(got.extra_hit));
            compare_field("hit_total", exp.hits, got.hits);
            compare_field("miss_total", exp.misses, got.misses);
            compare_field("eviction_total", exp.evictions, got.evictions);
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // opcode[1:0], address[65:2]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;   // outcome[1:0], extra_hit[2], hit_total[34:3],
                                      // miss_total[66:35], eviction_total[98:67]

    cache_tracker tracker = new();

    // Sender burst shaping and receiver stall pattern.
    int burst_left;
    int stall_mode = 0;
    int stall_left = 0;

    set_assoc_lru_cache_model_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 clk = ~clk;

    // The receiver switches between three stall patterns: always ready, ready at
    // random on half the cycles, and ready at random on one cycle in four. Each pattern
    // holds for a random stretch so that stalls land on every phase of the
    // block's fetch and exec states and its output register.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 80);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Every result transfer is checked at the edge that completes it.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_outcome(m_tdata);
    end

    // Offers one access and holds it until the block takes the transfer. The
    // valid stays high across a burst; at the end of a burst it drops for a
    // random gap before the next access, so it is never lowered and raised in
    // the same step.
    task automatic send_access(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] addr);
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - ADDR_W - OPCODE_W){1'b0}}, addr, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_access(op, addr);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
        else
            burst_left--;
    endtask

    // Lowers valid and waits until every queued outcome has been seen, so that
    // registers change only while idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes all three geometry registers on consecutive edges. The enable stays
    // high across the three writes and drops once afterward.
    task automatic set_geometry(logic [CFG_DATA_W-1:0] sb, logic [CFG_DATA_W-1:0] bb,
                                logic [CFG_DATA_W-1:0] nw);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SET_BITS;
        cfg_data <= sb;
        @(posedge clk);
        tracker.write_reg(CFG_SET_BITS, sb);
        cfg_index <= CFG_BLOCK_BITS;
        cfg_data <= bb;
        @(posedge clk);
        tracker.write_reg(CFG_BLOCK_BITS, bb);
        cfg_index <= CFG_WAYS;
        cfg_data <= nw;
        @(posedge clk);
        tracker.write_reg(CFG_WAYS, nw);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Builds an address that lands in a few low sets (now and then the top set)
    // with a tag from a small window above tag_base, so that hits, fills and
    // evictions all occur often. The block offset is random.
    function automatic logic [ADDR_W-1:0] pick_address(logic [TAG_W-1:0] tag_base);
        int sb;
        int nsets;
        int split;
        logic [ADDR_W-1:0] set_val;
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] byte_sel_mask;
        sb = tracker.usable_set_bits();
        nsets = 1 << sb;
        split = int'(tracker.block_bits) + sb;
        if ($urandom_range(0, 9) == 0)
            set_val = ADDR_W'(nsets - 1);
        else
            set_val = ADDR_W'($urandom_range(0, (nsets < 4) ? nsets - 1 : 3));
        tag = tag_base + $urandom_range(0, tracker.usable_ways() + 1);
        byte_sel_mask = (tracker.block_bits == 0) ? '0
                        : ({ADDR_W{1'b1}} >> (64 - tracker.block_bits));
        return ((split >= 64) ? '0 : (tag << split)) | (set_val << tracker.block_bits)
               | ({$urandom, $urandom} & byte_sel_mask);
    endfunction

    // Geometry of each random phase: set_bits, block_bits, ways. The list holds
    // the extremes: set_bits above the storage, the widest offset, zero ways and
    // way counts above the storage. Lines are kept across the changes.
    localparam int PHASES = 8;
    localparam logic [CFG_DATA_W-1:0] PHASE_SB[PHASES] = '{6'd2, 6'd6, 6'd7, 6'd0,
                                                           6'd3, 6'd1, 6'd5, 6'd4};
    localparam logic [CFG_DATA_W-1:0] PHASE_BB[PHASES] = '{6'd4, 6'd6, 6'd63, 6'd0,
                                                           6'd32, 6'd1, 6'd12, 6'd20};
    localparam logic [CFG_DATA_W-1:0] PHASE_NW[PHASES] = '{6'd4, 6'd8, 6'd15, 6'd0,
                                                           6'd2, 6'd3, 6'd9, 6'd8};
    localparam int ITEMS_PER_PHASE = 166;

    initial
    begin
        logic [TAG_W-1:0]    tag_base;
        logic [OPCODE_W-1:0] op;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SET_BITS;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        burst_left = $urandom_range(0, 40);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: one set, no offset, one way, so the tag is the whole
        // address. Covers every opcode, including the unknown one, and the
        // extreme addresses.
        send_access(OP_LOAD, 64'h0);
        send_access(OP_STORE, 64'h0);
        send_access(OP_MODIFY, 64'h0);
        send_access(OP_UNKNOWN, 64'h0);
        send_access(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(OP_STORE, 64'h8000_0000_0000_0000);
        send_access(OP_LOAD, 64'h5555_5555_5555_5555);
        send_access(OP_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_access(OP_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
        drain();

        // Wide split: 63 offset bits plus one set bit leave no tag, and the set
        // index is address bit 63 alone.
        set_geometry(6'd1, 6'd63, 6'd2);
        send_access(OP_LOAD, 64'h0);
        send_access(OP_LOAD, 64'h8000_0000_0000_0000);
        send_access(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(OP_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
        drain();

        // Two ways in set 0, which still holds older lines: two misses evict those,
        // the first is refreshed, then three misses each evict the least recently used line.
        set_geometry(6'd2, 6'd2, 6'd2);
        send_access(OP_LOAD, 64'h100);
        send_access(OP_LOAD, 64'h200);
        send_access(OP_STORE, 64'h103);
        send_access(OP_LOAD, 64'h300);
        send_access(OP_MODIFY, 64'h200);
        send_access(OP_LOAD, 64'h100);
        drain();

        // Random phases: mostly structured addresses that collide in a few sets,
        // with some fully random addresses as noise.
        for (int p = 0; p < PHASES; p++)
        begin
            set_geometry(PHASE_SB[p], PHASE_BB[p], PHASE_NW[p]);
            tag_base = {$urandom, $urandom};
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                op = OPCODE_W'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < 85)
                    send_access(op, pick_address(tag_base));
                else
                    send_access(op, {$urandom, $urandom});
            end
            drain();
        end

        if (tracker.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, with every access waiting
    // out the longest sender gap and the slowest receiver pattern.
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
sv/salc_pkg.sv
sv/salc_front.sv
sv/salc_queue.sv
sv/salc_back.sv
sv/set_assoc_lru_cache_model_unit.sv
bench/testbench.sv
